// ===== rtl/cbrm_pkg.sv =====
// Shared types and constants of the compressed block range mapper.
// Used by every module of the block but cbrm_ram; depends on nothing else.
package cbrm_pkg;

  localparam int unsigned MaxBlocksDefault = 4096;
  localparam int unsigned PageBitsDefault  = 12;
  localparam int unsigned QueueDepth       = 2;

  localparam int unsigned OffW    = 48;
  localparam int unsigned LenW    = 16;
  localparam int unsigned PageW   = 36;
  localparam int unsigned SectorW = 39;
  localparam int unsigned CountW  = 16;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned SectorBits = 9;

  localparam logic [OffW-1:0] BaseOffset    = OffW'(512);
  localparam logic [LenW-1:0] ChecksumBytes = LenW'(4);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_MAP    = 2'd1,
    OP_LOCATE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_RANGE    = 2'd1,
    STS_FULL     = 2'd2,
    STS_UNLOADED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_MAP,
    CMD_LOCATE,
    CMD_REJECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [LenW-1:0]   len;
    logic [OffW-1:0]   sidx;
    logic [OffW-1:0]   eidx;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [OffW-1:0]    begin_offset;
    logic [OffW-1:0]    byte_length;
    logic [PageW-1:0]   first_page;
    logic [PageW-1:0]   page_count;
    logic [PageW-1:0]   full_pages;
    logic               single_page;
  } res_t;

endpackage

// ===== rtl/cbrm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing else.
module cbrm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cbrm_front.sv =====
// Front end: accepts requests, checks map bounds and forms block indices.
// Depends on cbrm_pkg.
module cbrm_front import cbrm_pkg::*; (
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [LenW-1:0]    entry_length_i,
  input  logic [SectorW-1:0] start_sector_i,
  input  logic [CountW-1:0]  sector_count_i,
  input  logic [IndexW-1:0]  block_index_i,
  input  logic [ShiftW-1:0]  block_shift_i,
  input  logic [OffW-1:0]    virtual_size_i,
  input  logic               q_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [OffW-1:0]    start_byte;
  logic [SectorW:0]   end_sec;
  logic [SectorW:0]   last_sec;
  logic [OffW:0]      end_byte;
  logic [OffW:0]      last_byte;
  logic [OffW:0]      last_blk;
  logic               range_err;

  assign start_byte = {start_sector_i, {SectorBits{1'b0}}};
  assign end_sec    = {1'b0, start_sector_i} + (SectorW+1)'(sector_count_i);
  assign last_sec   = end_sec - (SectorW+1)'(1);
  assign end_byte   = {end_sec, {SectorBits{1'b0}}};
  assign last_byte  = {last_sec, {SectorBits{1'b0}}};
  assign last_blk   = last_byte >> block_shift_i;

  assign range_err = (sector_count_i == '0) || (start_byte >= virtual_size_i) ||
                     (end_byte > {1'b0, virtual_size_i});

  always_comb begin
    cmd_o.len  = entry_length_i;
    cmd_o.sidx = start_byte >> block_shift_i;
    cmd_o.eidx = last_blk[OffW-1:0];
    case (opcode_e'(opcode_i))
      OP_APPEND: cmd_o.kind = CMD_APPEND;
      OP_MAP:    cmd_o.kind = range_err ? CMD_REJECT : CMD_MAP;
      OP_LOCATE: begin
        cmd_o.kind = CMD_LOCATE;
        cmd_o.sidx = OffW'(block_index_i);
      end
      default:   cmd_o.kind = CMD_REJECT;
    endcase
  end

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

endmodule

// ===== rtl/cbrm_queue.sv =====
// Short command queue between the front end and the table sequencer.
// Depends on cbrm_pkg.
module cbrm_queue import cbrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign do_push = push_i && (cnt_q != CntW'(QueueDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

endmodule

// ===== rtl/cbrm_back.sv =====
// Table sequencer: owns the block table RAM, the entry count and the result register.
// Depends on cbrm_pkg and cbrm_ram.
module cbrm_back import cbrm_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault,
  parameter int unsigned PAGE_BITS  = PageBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  input  logic verify_i,
  output logic m_valid_o,
  input  logic m_ready_i,
  output res_t result_o
);

  localparam int unsigned AddrW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned EntW   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EntryW = OffW + LenW;
  localparam logic [OffW:0] PageMask = ((OffW+1)'(1) << PAGE_BITS) - (OffW+1)'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_SPAN_SUB,
    S_RD_ONE,
    S_END,
    S_PAGES
  } state_e;

  state_e            state_q;
  logic [EntW-1:0]   count_q;
  logic [OffW-1:0]   next_off_q;
  logic [OffW-1:0]   begin_q, len_q, sum_q;
  logic [OffW:0]     end_q;
  logic [AddrW-1:0]  eidx_q;
  logic              is_loc_q;
  logic              out_valid_q;
  res_t              out_q;

  logic              take, table_full;
  logic              map_go, loc_go, out_load;
  res_t              imm_res;
  logic [OffW-1:0]   count_ext;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic [OffW-1:0]   rd_off;
  logic [LenW-1:0]   rd_len;
  logic [OffW:0]     begin_pg, end_pg;
  logic [PageW-1:0]  full_pg, cnt_pg;
  logic              partial;

  assign take       = (state_q == S_IDLE) && q_valid_i && (!out_valid_q || m_ready_i);
  assign table_full = (count_q >= EntW'(MAX_BLOCKS));
  assign count_ext  = OffW'(count_q);

  assign map_go   = (q_cmd_i.kind == CMD_MAP) && (q_cmd_i.eidx < count_ext);
  assign loc_go   = (q_cmd_i.kind == CMD_LOCATE) && (q_cmd_i.sidx < count_ext);
  assign out_load = (state_q == S_PAGES) || (take && !map_go && !loc_go);

  always_comb begin
    imm_res = '0;
    case (q_cmd_i.kind)
      CMD_APPEND: begin
        if (table_full) begin
          imm_res.status = STS_FULL;
        end else begin
          imm_res.begin_offset = next_off_q;
          imm_res.byte_length  = OffW'(q_cmd_i.len);
        end
      end
      CMD_MAP, CMD_LOCATE: imm_res.status = STS_UNLOADED;
      default:             imm_res.status = STS_RANGE;
    endcase
  end

  assign ram_we    = take && (q_cmd_i.kind == CMD_APPEND) && !table_full;
  assign ram_waddr = count_q[AddrW-1:0];
  assign ram_wdata = {next_off_q, q_cmd_i.len};
  assign ram_raddr = (state_q == S_IDLE) ? q_cmd_i.sidx[AddrW-1:0] : eidx_q;

  cbrm_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_off = ram_rdata[EntryW-1:LenW];
  assign rd_len = ram_rdata[LenW-1:0];

  assign begin_pg = {1'b0, begin_q} >> PAGE_BITS;
  assign end_pg   = end_q >> PAGE_BITS;
  assign full_pg  = end_pg[PageW-1:0] - begin_pg[PageW-1:0];
  assign partial  = |(end_q & PageMask);
  assign cnt_pg   = full_pg + PageW'(partial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      next_off_q  <= BaseOffset;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            out_q <= imm_res;
            case (q_cmd_i.kind)
              CMD_APPEND: begin
                if (!table_full) begin
                  next_off_q <= next_off_q + OffW'(q_cmd_i.len);
                  count_q    <= count_q + EntW'(1);
                end
              end
              CMD_MAP: begin
                if (map_go) begin
                  eidx_q   <= q_cmd_i.eidx[AddrW-1:0];
                  is_loc_q <= 1'b0;
                  state_q  <= S_RD_FIRST;
                end
              end
              CMD_LOCATE: begin
                if (loc_go) begin
                  is_loc_q <= 1'b1;
                  state_q  <= S_RD_ONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_FIRST: begin
          begin_q <= rd_off;
          state_q <= S_RD_LAST;
        end
        S_RD_LAST: begin
          sum_q   <= rd_off + OffW'(rd_len);
          state_q <= S_SPAN_SUB;
        end
        S_SPAN_SUB: begin
          len_q   <= sum_q - begin_q;
          state_q <= S_END;
        end
        S_RD_ONE: begin
          begin_q <= rd_off;
          if (!verify_i) begin
            len_q <= OffW'(rd_len);
          end else if (rd_len >= ChecksumBytes) begin
            len_q <= OffW'(rd_len - ChecksumBytes);
          end else begin
            len_q <= '0;
          end
          state_q <= S_END;
        end
        S_END: begin
          end_q   <= {1'b0, begin_q} + {1'b0, len_q};
          state_q <= S_PAGES;
        end
        S_PAGES: begin
          out_q.status       <= STS_OK;
          out_q.begin_offset <= begin_q;
          out_q.byte_length  <= len_q;
          out_q.first_page   <= begin_pg[PageW-1:0];
          out_q.page_count   <= cnt_pg;
          out_q.full_pages   <= full_pg;
          out_q.single_page  <= is_loc_q && (cnt_pg == PageW'(1));
          state_q            <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign q_pop_o   = take;
  assign m_valid_o = out_valid_q;
  assign result_o  = out_q;

endmodule

// ===== rtl/compressed_block_range_mapper.sv =====
// Top level of the compressed block range mapper: configuration registers and stream ports.
// Depends on cbrm_pkg, cbrm_front, cbrm_queue and cbrm_back.
//
// Requests enter on the slave stream and pass through a two-entry command queue to a
// sequencer that owns one MAX_BLOCKS x 64-bit table RAM with one write and one registered
// read port. After the queue, appends, rejected requests and those naming an unloaded block
// are answered from the idle state; a locate reads the table once and a map twice over the
// single RAM read port before the page steps. The table needs no clearing pass after reset.
// Configuration registers are to be written only while no request is in flight.
module compressed_block_range_mapper import cbrm_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault,
  parameter int unsigned PAGE_BITS  = PageBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [47:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_length, start_sector, sector_count, block_index, zero padding
  input  logic [87:0]  s_axis_tdata,
  // opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // begin_offset, byte_length, first_page, page_count, full_pages, single_page, zero padding
  output logic [207:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  localparam logic [1:0] CfgBlockShift = 2'd0;
  localparam logic [1:0] CfgVerify     = 2'd1;
  localparam logic [1:0] CfgVirtSize   = 2'd2;

  logic [ShiftW-1:0] block_shift_q;
  logic              verify_q;
  logic [OffW-1:0]   virt_size_q;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t front_cmd, q_cmd;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_shift_q <= ShiftW'(12);
      verify_q      <= 1'b0;
      virt_size_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBlockShift: block_shift_q <= cfg_data_i[ShiftW-1:0];
        CfgVerify:     verify_q      <= cfg_data_i[0];
        CfgVirtSize:   virt_size_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cbrm_front u_front (
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .opcode_i       (s_axis_tuser),
    .entry_length_i (s_axis_tdata[15:0]),
    .start_sector_i (s_axis_tdata[54:16]),
    .sector_count_i (s_axis_tdata[70:55]),
    .block_index_i  (s_axis_tdata[82:71]),
    .block_shift_i  (block_shift_q),
    .virtual_size_i (virt_size_q),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .cmd_o          (front_cmd)
  );

  cbrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  cbrm_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .verify_i  (verify_q),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {3'b000, res.single_page, res.full_pages, res.page_count,
                         res.first_page, res.byte_length, res.begin_offset};

  // A result with any status but ok carries an all-zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res.status != STS_OK)) |-> (m_axis_tdata == '0))
    else $error("non-ok result with nonzero payload");

  // A single-page result must be an ok result spanning exactly one page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.single_page) |->
      ((res.status == STS_OK) && (res.page_count == PageW'(1))))
    else $error("single_page set without a one-page span");

  // The full_pages count equals the page count or falls short of it by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res.status == STS_OK)) |->
      ((res.full_pages == res.page_count) ||
       (PageW'(res.full_pages + PageW'(1)) == res.page_count)))
    else $error("full_pages inconsistent with page_count");

endmodule

// ===== tb/cbrm_tb_pkg.sv =====
`timescale 1ns / 1ps
// Request type, register indexes and the reply scoreboard of the range mapper testbench.
// Depends on cbrm_pkg for widths, opcodes, status codes and the reply layout.
package cbrm_tb_pkg;
  import cbrm_pkg::*;

  localparam logic [1:0] RegBlockShift  = 2'd0;
  localparam logic [1:0] RegVerify      = 2'd1;
  localparam logic [1:0] RegVirtualSize = 2'd2;
  localparam logic [1:0] OpUnused       = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [LenW-1:0]    entry_length;
    logic [SectorW-1:0] start_sector;
    logic [CountW-1:0]  sector_count;
    logic [IndexW-1:0]  block_index;
  } request_t;

  class extent_scoreboard;
    logic [OffW-1:0] offsets [MaxBlocksDefault+1];
    logic [LenW-1:0] lengths [MaxBlocksDefault];
    int unsigned     loaded;
    int unsigned     shift;
    bit              verify;
    logic [63:0]     vsize;
    res_t            expected_replies [$];
    int unsigned     mismatches;
    int unsigned     replies;
    int unsigned     status_seen [4];

    function new();
      offsets[0] = BaseOffset;
      loaded     = 0;
      shift      = 12;
      verify     = 1'b0;
      vsize      = '0;
      mismatches = 0;
      replies    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void apply_config(logic [1:0] idx, logic [47:0] value);
      case (idx)
        RegBlockShift:  shift = value[ShiftW-1:0];
        RegVerify:      verify = value[0];
        RegVirtualSize: vsize = 64'(value);
        default: ;
      endcase
    endfunction

    function void fill_pages(inout res_t r);
      logic [63:0] psize, last, left, right, pages;
      psize = 64'd1 << PageBitsDefault;
      last  = 64'(r.begin_offset) + 64'(r.byte_length);
      left  = 64'(r.begin_offset) & ~(psize - 64'd1);
      right = (last + psize - 64'd1) & ~(psize - 64'd1);
      pages = (right - left) >> PageBitsDefault;
      r.first_page = PageW'(left >> PageBitsDefault);
      r.page_count = PageW'(pages);
      r.full_pages = PageW'(pages - ((right > last) ? 64'd1 : 64'd0));
    endfunction

    function void note_request(request_t req);
      res_t        r;
      logic [63:0] first_byte, end_byte, first_blk, last_blk, base;
      logic [LenW-1:0] payload;
      r = '0;
      case (req.op)
        OP_APPEND: begin
          if (loaded >= MaxBlocksDefault) begin
            r.status = STS_FULL;
          end else begin
            r.begin_offset = offsets[loaded];
            r.byte_length = OffW'(req.entry_length);
            lengths[loaded] = req.entry_length;
            offsets[loaded+1] = OffW'(64'(offsets[loaded]) + 64'(req.entry_length));
            loaded++;
          end
        end
        OP_MAP: begin
          first_byte = 64'(req.start_sector) << SectorBits;
          end_byte = (64'(req.start_sector) + 64'(req.sector_count)) << SectorBits;
          if (req.sector_count == '0 || first_byte >= vsize || end_byte > vsize) begin
            r.status = STS_RANGE;
          end else begin
            first_blk = first_byte >> shift;
            last_blk = (end_byte - 64'd512) >> shift;
            if (last_blk >= 64'(loaded)) begin
              r.status = STS_UNLOADED;
            end else begin
              base = 64'(offsets[first_blk]);
              r.begin_offset = OffW'(base);
              r.byte_length = OffW'(64'(offsets[last_blk]) + 64'(lengths[last_blk]) - base);
              fill_pages(r);
            end
          end
        end
        OP_LOCATE: begin
          if (32'(req.block_index) >= loaded) begin
            r.status = STS_UNLOADED;
          end else begin
            payload = lengths[req.block_index];
            if (verify) begin
              payload = (payload >= ChecksumBytes) ? payload - ChecksumBytes : '0;
            end
            r.begin_offset = offsets[req.block_index];
            r.byte_length = OffW'(payload);
            fill_pages(r);
            r.single_page = (r.page_count == PageW'(1));
          end
        end
        default: r.status = STS_RANGE;
      endcase
      expected_replies.push_back(r);
    endfunction

    function string show(res_t r);
      return $sformatf("%0d/%h/%h/%h/%h/%h/%b", r.status, r.begin_offset, r.byte_length,
                       r.first_page, r.page_count, r.full_pages, r.single_page);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    function void check_reply(logic [207:0] data, logic [1:0] user);
      res_t want, got;
      got.status       = status_e'(user);
      got.begin_offset = data[47:0];
      got.byte_length  = data[95:48];
      got.first_page   = data[131:96];
      got.page_count   = data[167:132];
      got.full_pages   = data[203:168];
      got.single_page  = data[204];
      if (expected_replies.size() == 0) begin
        flag($sformatf("reply with no request waiting: %s", show(got)));
        return;
      end
      want = expected_replies.pop_front();
      replies++;
      status_seen[want.status]++;
      if (got.status !== want.status || got.begin_offset !== want.begin_offset ||
          got.byte_length !== want.byte_length || got.first_page !== want.first_page ||
          got.page_count !== want.page_count || got.full_pages !== want.full_pages ||
          got.single_page !== want.single_page) begin
        flag($sformatf("status/offset/length/page/pages/full/single expected %s got %s",
                       show(want), show(got)));
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_compressed_block_range_mapper.sv =====
`timescale 1ns / 1ps
// Top of the range mapper testbench: clock, reset, request and reply drivers, register
// phases, a watchdog and the verdict. Depends on cbrm_pkg, cbrm_tb_pkg and the block.
module tb_compressed_block_range_mapper;
  import cbrm_pkg::*;
  import cbrm_tb_pkg::*;

  localparam int unsigned PhaseItems    = 170;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned StallCycles   = 400;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned WatchdogLimit = 3000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [47:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  extent_scoreboard sb;
  int unsigned      src_idle_max = 18;
  int unsigned      snk_idle_max = 18;
  bit               hold_req = 1'b0;
  int unsigned      sent = 0;
  int unsigned      phases = 0;

  compressed_block_range_mapper dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand_below(logic [63:0] n);
    return (n == 64'd0) ? 64'd0 : {$urandom, $urandom} % n;
  endfunction

  function automatic request_t random_fields();
    request_t r;
    r.op           = 2'($urandom);
    r.entry_length = 16'($urandom);
    r.start_sector = SectorW'({$urandom, $urandom});
    r.sector_count = 16'($urandom);
    r.block_index  = IndexW'($urandom);
    return r;
  endfunction

  task automatic send_request(request_t req);
    int unsigned gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req.op;
    s_axis_tdata <= {5'b0, req.block_index, req.sector_count, req.start_sector,
                     req.entry_length};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req);
    sent++;
  endtask

  task automatic send_fields(logic [1:0] op, logic [15:0] len, logic [38:0] start,
                             logic [15:0] cnt, logic [11:0] idx);
    request_t req;
    req.op = op;
    req.entry_length = len;
    req.start_sector = start;
    req.sector_count = cnt;
    req.block_index = idx;
    send_request(req);
  endtask

  task automatic random_request();
    request_t    req;
    logic [63:0] covered, limit, sectors, first, room, cnt;
    int unsigned pick;
    req = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      req.op = OP_APPEND;
      case ($urandom_range(0, 9))
        0: req.entry_length = 16'($urandom_range(0, 3));
        1: req.entry_length = '1;
        2, 3: ;
        default: req.entry_length = 16'($urandom_range(1, 6000));
      endcase
    end else if (pick < 60) begin
      req.op = OP_MAP;
      covered = 64'(sb.loaded) << sb.shift;
      limit = (covered < sb.vsize) ? covered : sb.vsize;
      sectors = limit >> SectorBits;
      if (sectors != 64'd0 && $urandom_range(0, 9) != 0) begin
        first = rand_below(sectors);
        room = sectors - first;
        if (room > 64'hFFFF) room = 64'hFFFF;
        room = room >> $urandom_range(0, 15);
        cnt = 64'd1 + rand_below(room);
        if ($urandom_range(0, 7) == 0) cnt++;
        req.start_sector = SectorW'(first);
        req.sector_count = CountW'(cnt);
      end
    end else if (pick < 88) begin
      req.op = OP_LOCATE;
      if (sb.loaded != 0 && $urandom_range(0, 4) != 0) begin
        req.block_index = IndexW'(rand_below(64'(sb.loaded)));
      end
    end else begin
      req.op = 2'($urandom_range(0, 3));
    end
    send_request(req);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [47:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    sb.apply_config(idx, value);
    @(posedge clk_i);
  endtask

  task automatic write_config(int unsigned shift, bit verify, logic [47:0] vsize);
    write_register(RegBlockShift, 48'(shift));
    write_register(RegVerify, 48'(verify));
    write_register(RegVirtualSize, vsize);
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  // Replies are taken with random stalls; one long hold-off lets the block fill up.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, snk_idle_max);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
      end else if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_reply(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog expired with %0d replies outstanding.", sb.expected_replies.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned shift;
    logic [47:0] vsize;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small blocks of one sector, checksums on, and an image of eight sectors.
    write_config(9, 1'b1, 48'd4096);
    send_fields(OP_LOCATE, '0, '0, '0, '0);
    send_fields(OP_MAP, '0, '0, 16'd1, '0);
    send_fields(OP_APPEND, 16'd0, '0, '0, '0);
    send_fields(OP_APPEND, 16'd3, '0, '0, '0);
    send_fields(OP_APPEND, 16'd4, '0, '0, '0);
    send_fields(OP_APPEND, 16'hFFFF, '0, '0, '0);
    send_fields(OP_APPEND, 16'd1, '0, '0, '0);
    send_fields(OP_APPEND, 16'd5000, '0, '0, '0);
    send_fields(OP_APPEND, 16'd4095, '0, '0, '0);
    send_fields(OP_LOCATE, '0, '0, '0, 12'd0);
    send_fields(OP_LOCATE, '0, '0, '0, 12'd1);
    send_fields(OP_LOCATE, '0, '0, '0, 12'd2);
    send_fields(OP_LOCATE, '0, '0, '0, 12'd3);
    send_fields(OP_LOCATE, '0, '0, '0, '1);
    send_fields(OP_MAP, '0, '0, '0, '0);
    send_fields(OP_MAP, '0, '1, '1, '0);
    send_fields(OP_MAP, '0, 39'd7, 16'd2, '0);
    send_fields(OP_MAP, '0, 39'd8, 16'd1, '0);
    send_fields(OP_MAP, '0, 39'd0, 16'd7, '0);
    send_fields(OP_MAP, '0, 39'd2, 16'd3, '0);
    send_fields(OpUnused, '1, '1, '1, '1);
    send_fields(OP_APPEND, 16'd100, '0, '0, '0);
    send_fields(OP_MAP, '0, 39'd0, 16'd8, '0);
    send_fields(OP_LOCATE, '0, '0, '0, 12'd7);

    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      shift = (p == 0) ? 9 : (p == 1) ? 20 : $urandom_range(9, 20);
      case (p)
        2: vsize = '1;
        5: vsize = '0;
        default: vsize = 48'(((64'(sb.loaded) + 64'd48) << shift) - $urandom_range(0, 4095));
      endcase
      write_config(shift, p[0], vsize);
      src_idle_max = (p % 3 == 2) ? 0 : 18;
      snk_idle_max = (p % 4 == 3) ? 0 : 18;
      if (p == 1) hold_req = 1'b1;
      repeat (PhaseItems) random_request();
    end

    // Close with the widest image and requests aimed at the far end of the table.
    settle();
    src_idle_max = 2;
    snk_idle_max = 2;
    write_config(9, 1'b1, '1);
    send_fields(OP_APPEND, '1, '0, '0, '0);
    send_fields(OP_APPEND, 16'd0, '0, '0, '0);
    send_fields(OP_LOCATE, '0, '0, '0, '1);
    send_fields(OP_MAP, '0, 39'd4095, 16'd1, '0);
    send_fields(OP_MAP, '0, 39'd0, 16'd4096, '0);
    send_fields(OP_MAP, '0, 39'd0, 16'd4097, '0);
    repeat (60) random_request();
    settle();

    $display("Run covered %0d requests over %0d register settings, table holding %0d blocks.",
             sent, phases, sb.loaded);
    $display("Replies: %0d ok, %0d out of range, %0d full, %0d not loaded; %0d mismatches.",
             sb.status_seen[STS_OK], sb.status_seen[STS_RANGE], sb.status_seen[STS_FULL],
             sb.status_seen[STS_UNLOADED], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== compressed_block_range_mapper.f =====
rtl/cbrm_pkg.sv
rtl/cbrm_ram.sv
rtl/cbrm_front.sv
rtl/cbrm_queue.sv
rtl/cbrm_back.sv
rtl/compressed_block_range_mapper.sv
tb/cbrm_tb_pkg.sv
tb/tb_compressed_block_range_mapper.sv
